>>> hw/rtl/ccw_pkg.sv
// Shared constants, codes and the result record type for the chunk chain walker.
// Used by ccw_parse, ccw_outq and chunk_chain_walker; depends on nothing else.
package ccw_pkg;

    localparam int HEADER_BYTES = 16;
    localparam int COUNT_W      = 18;

    localparam logic [COUNT_W-1:0] MAX_ENTRIES = 18'd200000;

    localparam logic [31:0] MAGIC_PLAIN   = 32'h4C78_4746;
    localparam logic [31:0] MAGIC_OCCL    = 32'h4F78_4746;
    localparam logic [31:0] HDR_WORD_SIZE = 32'd10;
    localparam logic [31:0] HDR_WORD_ONE  = 32'd1;
    localparam logic [31:0] MIN_ENTRY     = 32'd8;

    // Input kinds.
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

    // Result kinds.
    localparam logic RK_ENTRY  = 1'b0;
    localparam logic RK_STATUS = 1'b1;

    // Walk status codes.
    localparam logic [2:0] ST_COMPLETE   = 3'd0;
    localparam logic [2:0] ST_NOT_MAGIC  = 3'd1;
    localparam logic [2:0] ST_HEADER_BAD = 3'd2;
    localparam logic [2:0] ST_RAN_OFF    = 3'd3;
    localparam logic [2:0] ST_NO_SIZE    = 3'd4;
    localparam logic [2:0] ST_BAD_SIZE   = 3'd5;
    localparam logic [2:0] ST_TOO_MANY   = 3'd6;

    // Register index decoded from paddr.
    localparam logic REG_FILE_LENGTH = 1'b0;

    // Output queue geometry.
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = 2;
    localparam int OUTQ_CW    = 3;

    typedef struct packed {
        logic               result_kind;
        logic [31:0]        entry_tag;
        logic [31:0]        entry_size;
        logic [31:0]        entry_offset;
        logic [2:0]         status;
        logic               occluder;
        logic [COUNT_W-1:0] entry_count;
        logic               last;
    } result_t;

endpackage

>>> hw/rtl/ccw_parse.sv
// Walk state and per-byte decision logic of the chunk chain walker.
// Produces up to two result records for each accepted transaction; uses ccw_pkg.
module ccw_parse import ccw_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        accept,
    input  logic        in_kind,
    input  logic [7:0]  in_byte,
    input  logic [31:0] file_length,
    output result_t     res0,
    output result_t     res1,
    output logic [1:0]  n_res
);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_BODY   = 3'd1;
    localparam logic [2:0] PH_TAG    = 3'd2;
    localparam logic [2:0] PH_SIZE   = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    logic [31:0]        pos_reg,   pos_next;
    logic [31:0]        start_reg, start_next;
    logic [2:0]         phase_reg, phase_next;
    logic [31:0]        tag_reg,   tag_next;
    logic [31:0]        size_reg,  size_next;
    logic [31:0]        hdr_reg,   hdr_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               var_reg,   var_next;
    logic [2:0]         ofs_reg,   ofs_next;

    logic [31:0] tag_sh, size_sh, hdr_sh;
    logic [32:0] len33, start8, start4, start12, start_sz;
    logic [COUNT_W-1:0] count_inc;

    assign tag_sh    = {in_byte, tag_reg[31:8]};
    assign size_sh   = {in_byte, size_reg[31:8]};
    assign hdr_sh    = {in_byte, hdr_reg[31:8]};
    assign len33     = {1'b0, file_length};
    assign start4    = {1'b0, start_reg} + 33'd4;
    assign start8    = {1'b0, start_reg} + 33'd8;
    assign start12   = {1'b0, start_reg} + 33'd12;
    assign start_sz  = {1'b0, start_reg} + {1'b0, size_sh};
    assign count_inc = count_reg + 1'b1;

    function automatic result_t mk(input logic rk, input logic [31:0] tag,
                                   input logic [31:0] size, input logic [31:0] off,
                                   input logic [2:0] st, input logic occ,
                                   input logic [COUNT_W-1:0] cnt);
        result_t r;
        r.result_kind  = rk;
        r.entry_tag    = tag;
        r.entry_size   = size;
        r.entry_offset = off;
        r.status       = st;
        r.occluder     = occ;
        r.entry_count  = cnt;
        r.last         = 1'b0;
        return r;
    endfunction

    always_comb begin
        logic done;
        logic enter_tag;
        logic runoff;
        pos_next   = pos_reg;
        start_next = start_reg;
        phase_next = phase_reg;
        tag_next   = tag_reg;
        size_next  = size_reg;
        hdr_next   = hdr_reg;
        count_next = count_reg;
        var_next   = var_reg;
        ofs_next   = ofs_reg;
        res0       = '0;
        res1       = '0;
        n_res      = 2'd0;
        done       = 1'b0;
        enter_tag  = 1'b0;
        runoff     = 1'b0;
        if (accept) begin
            if (in_kind == KIND_START) begin
                pos_next   = '0;
                start_next = 32'(HEADER_BYTES);
                phase_next = PH_HEADER;
                tag_next   = '0;
                size_next  = '0;
                hdr_next   = '0;
                count_next = '0;
                var_next   = 1'b0;
                ofs_next   = '0;
                if (len33 < 33'(HEADER_BYTES)) begin
                    res0       = mk(RK_STATUS, '0, '0, '0, ST_NOT_MAGIC, 1'b0, '0);
                    n_res      = 2'd1;
                    phase_next = PH_DONE;
                end
            end else if (phase_reg != PH_DONE) begin
                case (phase_reg)
                    PH_HEADER: begin
                        if (pos_reg < 32'd4) begin
                            hdr_next = hdr_sh;
                        end else if (pos_reg >= 32'd8 && pos_reg < 32'd12) begin
                            size_next = size_sh;
                        end else if (pos_reg >= 32'd12) begin
                            tag_next = tag_sh;
                        end
                        if (pos_reg == 32'd3) begin
                            if (len33 < 33'(HEADER_BYTES) ||
                                (hdr_sh != MAGIC_PLAIN && hdr_sh != MAGIC_OCCL)) begin
                                res0  = mk(RK_STATUS, '0, '0, '0, ST_NOT_MAGIC,
                                           var_reg, count_reg);
                                n_res = 2'd1;
                                done  = 1'b1;
                            end else begin
                                var_next = (hdr_sh == MAGIC_OCCL);
                            end
                        end else if (pos_reg >= 32'(HEADER_BYTES - 1)) begin
                            if (size_next != HDR_WORD_SIZE || tag_next != HDR_WORD_ONE) begin
                                res0  = mk(RK_STATUS, tag_next, size_next, 32'd8,
                                           ST_HEADER_BAD, var_reg, count_reg);
                                n_res = 2'd1;
                                done  = 1'b1;
                            end else begin
                                // The first entry starts right after the header.
                                phase_next = PH_BODY;
                                enter_tag  = 1'b1;
                                runoff     = len33 < 33'(HEADER_BYTES + 4);
                            end
                        end
                    end
                    PH_TAG: begin
                        tag_next = tag_sh;
                        ofs_next = ofs_reg + 3'd1;
                        if (ofs_reg == 3'd3) begin
                            if (tag_sh == '0) begin
                                res0  = mk(RK_STATUS, '0, '0, start_reg, ST_COMPLETE,
                                           var_reg, count_reg);
                                n_res = 2'd1;
                                done  = 1'b1;
                            end else if (start8 > len33) begin
                                res0  = mk(RK_STATUS, tag_sh, '0, start_reg, ST_NO_SIZE,
                                           var_reg, count_reg);
                                n_res = 2'd1;
                                done  = 1'b1;
                            end else begin
                                size_next  = '0;
                                phase_next = PH_SIZE;
                            end
                        end
                    end
                    PH_SIZE: begin
                        size_next = size_sh;
                        ofs_next  = ofs_reg + 3'd1;
                        if (ofs_reg == 3'd7) begin
                            if (size_sh < MIN_ENTRY || start_sz > len33) begin
                                res0  = mk(RK_STATUS, tag_reg, size_sh, start_reg,
                                           ST_BAD_SIZE, var_reg, count_reg);
                                n_res = 2'd1;
                                done  = 1'b1;
                            end else begin
                                count_next = count_inc;
                                start_next = start_sz[31:0];
                                res0  = mk(RK_ENTRY, tag_reg, size_sh, start_reg,
                                           ST_COMPLETE, var_reg, count_inc);
                                n_res = 2'd1;
                                if (count_inc >= MAX_ENTRIES) begin
                                    res1  = mk(RK_STATUS, '0, '0, start_sz[31:0],
                                               ST_TOO_MANY, var_reg, count_inc);
                                    n_res = 2'd2;
                                    done  = 1'b1;
                                end else begin
                                    // Only an eight-byte entry leaves no body to skip.
                                    phase_next = PH_BODY;
                                    enter_tag  = (size_sh == MIN_ENTRY);
                                    runoff     = start12 > len33;
                                end
                            end
                        end
                    end
                    default: begin
                        enter_tag = (pos_reg + 32'd1 == start_reg);
                        runoff    = start4 > len33;
                    end
                endcase
                if (done) begin
                    phase_next = PH_DONE;
                end else begin
                    pos_next = pos_reg + 32'd1;
                    if (phase_next == PH_BODY && enter_tag) begin
                        phase_next = PH_TAG;
                        tag_next   = '0;
                        ofs_next   = '0;
                        if (runoff) begin
                            if (n_res == 2'd0) begin
                                res0 = mk(RK_STATUS, '0, '0, start_next, ST_RAN_OFF,
                                          var_next, count_next);
                            end else begin
                                res1 = mk(RK_STATUS, '0, '0, start_next, ST_RAN_OFF,
                                          var_next, count_next);
                            end
                            n_res      = n_res + 2'd1;
                            phase_next = PH_DONE;
                        end
                    end
                end
            end
        end
        if (n_res == 2'd1) begin
            res0.last = 1'b1;
        end
        if (n_res == 2'd2) begin
            res1.last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            start_reg <= 32'(HEADER_BYTES);
            phase_reg <= PH_HEADER;
            tag_reg   <= '0;
            size_reg  <= '0;
            hdr_reg   <= '0;
            count_reg <= '0;
            var_reg   <= 1'b0;
            ofs_reg   <= '0;
        end else begin
            pos_reg   <= pos_next;
            start_reg <= start_next;
            phase_reg <= phase_next;
            tag_reg   <= tag_next;
            size_reg  <= size_next;
            hdr_reg   <= hdr_next;
            count_reg <= count_next;
            var_reg   <= var_next;
            ofs_reg   <= ofs_next;
        end
    end

    // A pair of results is always an entry record followed by a final status.
    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        n_res == 2'd2 |-> res0.result_kind == RK_ENTRY && res1.result_kind == RK_STATUS)
        else $error("two results out of order");

    // Any final status closes the walk.
    a_status_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (n_res == 2'd1 && res0.result_kind == RK_STATUS) || n_res == 2'd2
        |=> phase_reg == PH_DONE)
        else $error("walk continued after a final status");

    // The entry guard keeps the count within range.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_ENTRIES)
        else $error("entry count beyond the guard");

    // Data bytes after the final status give nothing.
    a_done_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DONE && accept && in_kind == KIND_DATA |=> $stable(phase_reg))
        else $error("finished walk reopened by a data byte");

endmodule

>>> hw/rtl/ccw_outq.sv
// Four-deep result queue of the chunk chain walker: takes up to two records a
// cycle and hands out one per transaction on the result channel; uses ccw_pkg.
module ccw_outq import ccw_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] push_n,
    input  result_t    push0,
    input  result_t    push1,
    input  logic       out_ready,
    output logic       out_valid,
    output result_t    out_data,
    output logic       room
);

    result_t              q_reg [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0]   wr_reg,    wr_next;
    logic [OUTQ_AW-1:0]   rd_reg,    rd_next;
    logic [OUTQ_CW-1:0]   count_reg, count_next;
    logic                 pop;
    logic [OUTQ_AW-1:0]   wr_plus1;

    assign out_valid  = (count_reg != '0);
    assign out_data   = q_reg[rd_reg];
    assign pop        = out_valid && out_ready;
    // Room for the worst case of two records from the next transaction.
    assign room       = count_reg <= OUTQ_CW'(OUTQ_DEPTH - 2);
    assign wr_plus1   = wr_reg + 1'b1;
    assign wr_next    = wr_reg + push_n;
    assign rd_next    = rd_reg + OUTQ_AW'(pop);
    assign count_next = count_reg + OUTQ_CW'(push_n) - OUTQ_CW'(pop);

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            q_reg[wr_reg] <= push0;
        end
        if (push_n == 2'd2) begin
            q_reg[wr_plus1] <= push1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= OUTQ_CW'(OUTQ_DEPTH))
        else $error("result queue overflow");

    a_fill_matches_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != OUTQ_CW'(OUTQ_DEPTH) |-> wr_reg - rd_reg == count_reg[OUTQ_AW-1:0])
        else $error("queue pointers disagree with fill level");

    // Records are pushed in the cycle of the accepting transaction, so room holds then.
    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push_n != 2'd0 |-> room)
        else $error("records pushed without room");

endmodule

>>> hw/rtl/chunk_chain_walker.sv
// Chunk chain walker: streams a tag/size chunk file a byte at a time and reports
// each entry and a final walk status. Top level; uses ccw_pkg, ccw_parse, ccw_outq.
//
// Usage. Write the file length through the register port (byte address 0) while
// the block is idle, then send a start transaction (s_tuser 0) followed by the
// file's bytes (s_tuser 1, byte in s_tdata). The block checks the magic word and
// the two header words, then walks the chained entries. Each good entry gives a
// record with m_tuser 0; the walk ends with one record with m_tuser 1 carrying
// the status. m_tlast marks the last record caused by one input transaction.
// Timing. Every input transaction is decided in the cycle it is accepted; its
// records go to the output queue, leaving one per cycle while m_tready is high.
// The block takes one byte per cycle; a byte can give two records, and the
// four-record output queue drops s_tready only when three or more records wait.
// When the receiver stalls, records queue up and input stops once the queue
// cannot take two more. Bytes after the final status are taken and ignored.
// Reset clears the walk state, empties the queue and sets the file length to 0.
module chunk_chain_walker import ccw_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    // Input channel. s_tdata: data_byte [7:0]. s_tuser: kind.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,
    input  logic         s_tuser,
    // Result channel. m_tdata: entry_tag [31:0], entry_size [63:32],
    // entry_offset [95:64], status [98:96], occluder [99],
    // entry_count [117:100], zero [119:118]. m_tuser: result_kind.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,
    output logic         m_tuser,
    output logic         m_tlast,
    // Register port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [31:0] file_length_reg, file_length_next;
    logic        accept;
    logic        room;
    result_t     res0, res1, head;
    logic [1:0]  n_res;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FILE_LENGTH) ? file_length_reg : 32'd0;

    always_comb begin
        file_length_next = file_length_reg;
        if (psel && penable && pwrite && pready && paddr[2] == REG_FILE_LENGTH) begin
            file_length_next = pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_length_reg <= '0;
        end else begin
            file_length_reg <= file_length_next;
        end
    end

    assign s_tready = room;
    assign accept   = s_tvalid && room;

    ccw_parse u_parse (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .in_kind     (s_tuser),
        .in_byte     (s_tdata),
        .file_length (file_length_reg),
        .res0        (res0),
        .res1        (res1),
        .n_res       (n_res)
    );

    ccw_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_n    (n_res),
        .push0     (res0),
        .push1     (res1),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (head),
        .room      (room)
    );

    assign m_tdata = {2'b00, head.entry_count, head.occluder, head.status,
                      head.entry_offset, head.entry_size, head.entry_tag};
    assign m_tuser = head.result_kind;
    assign m_tlast = head.last;

endmodule

>>> dv/chunk_chain_walker_tb.sv
// Self-checking testbench for chunk_chain_walker: streams chunk files through the
// input channel, predicts every record in a scoreboard and compares the result channel.
// Depends on ccw_pkg and the chunk_chain_walker RTL only.
module chunk_chain_walker_tb import ccw_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1300;
    localparam int PRESSURE_ENTRIES = 12;
    localparam longint CYCLE_LIMIT = 1_000_000;

    typedef enum logic [2:0] {
        WALK_HEADER,
        WALK_BODY,
        WALK_TAG,
        WALK_SIZE,
        WALK_DONE
    } walk_state_t;

    // Scoreboard: tracks the walk as the block should, and holds the records it must emit.
    class walk_scoreboard;
        logic [31:0]        flen;
        logic [31:0]        pos;
        logic [32:0]        base;
        walk_state_t        walk_state;
        logic [31:0]        magic_acc;
        logic [31:0]        tag_acc;
        logic [31:0]        size_acc;
        logic [COUNT_W-1:0] n_entries;
        logic               occl;
        result_t            pending_records[$];
        int                 errors;
        int                 records;
        int                 status_hits[7];

        function new();
            flen = '0;
            clear_walk();
        endfunction

        function void clear_walk();
            pos = '0;
            base = 33'(HEADER_BYTES);
            walk_state = WALK_HEADER;
            tag_acc = '0;
            size_acc = '0;
            magic_acc = '0;
            n_entries = '0;
            occl = 1'b0;
        endfunction

        function void queue_record(logic rk, logic [31:0] tag, logic [31:0] size,
                                   logic [31:0] offs, logic [2:0] st);
            result_t r;
            r.result_kind  = rk;
            r.entry_tag    = tag;
            r.entry_size   = size;
            r.entry_offset = offs;
            r.status       = st;
            r.occluder     = occl;
            r.entry_count  = n_entries;
            r.last         = 1'b0;
            pending_records.push_back(r);
        endfunction

        function void note_input(logic kind, logic [7:0] b);
            int          first;
            logic [63:0] offs;
            logic [33:0] len34;
            first = pending_records.size();
            len34 = {2'b00, flen};
            if (kind == KIND_START) begin
                clear_walk();
                if (flen < HEADER_BYTES) begin
                    queue_record(RK_STATUS, '0, '0, '0, ST_NOT_MAGIC);
                    walk_state = WALK_DONE;
                end
            end else if (walk_state != WALK_DONE) begin
                offs = {32'b0, pos} - {31'b0, base};
                case (walk_state)
                    WALK_HEADER: begin
                        if (pos < 4)
                            magic_acc = {b, magic_acc[31:8]};
                        else if (pos >= 8 && pos < 12)
                            size_acc = {b, size_acc[31:8]};
                        else if (pos >= 12)
                            tag_acc = {b, tag_acc[31:8]};
                        if (pos == 3) begin
                            if (flen < HEADER_BYTES ||
                                (magic_acc != MAGIC_PLAIN && magic_acc != MAGIC_OCCL)) begin
                                queue_record(RK_STATUS, '0, '0, '0, ST_NOT_MAGIC);
                                walk_state = WALK_DONE;
                            end else begin
                                occl = (magic_acc == MAGIC_OCCL);
                            end
                        end else if (pos >= HEADER_BYTES - 1) begin
                            if (size_acc != HDR_WORD_SIZE || tag_acc != HDR_WORD_ONE) begin
                                queue_record(RK_STATUS, tag_acc, size_acc, 32'd8,
                                             ST_HEADER_BAD);
                                walk_state = WALK_DONE;
                            end else begin
                                walk_state = WALK_BODY;
                            end
                        end
                    end
                    WALK_TAG: begin
                        tag_acc = {b, tag_acc[31:8]};
                        if (offs == 3) begin
                            if (tag_acc == 0) begin
                                queue_record(RK_STATUS, '0, '0, base[31:0], ST_COMPLETE);
                                walk_state = WALK_DONE;
                            end else if ({1'b0, base} + 34'd8 > len34) begin
                                queue_record(RK_STATUS, tag_acc, '0, base[31:0], ST_NO_SIZE);
                                walk_state = WALK_DONE;
                            end else begin
                                size_acc = '0;
                                walk_state = WALK_SIZE;
                            end
                        end
                    end
                    WALK_SIZE: begin
                        size_acc = {b, size_acc[31:8]};
                        if (offs == 7) begin
                            if (size_acc < MIN_ENTRY ||
                                {1'b0, base} + {2'b00, size_acc} > len34) begin
                                queue_record(RK_STATUS, tag_acc, size_acc, base[31:0],
                                             ST_BAD_SIZE);
                                walk_state = WALK_DONE;
                            end else begin
                                n_entries = n_entries + 1'b1;
                                queue_record(RK_ENTRY, tag_acc, size_acc, base[31:0],
                                             ST_COMPLETE);
                                base = base + {1'b0, size_acc};
                                if (n_entries >= MAX_ENTRIES) begin
                                    queue_record(RK_STATUS, '0, '0, base[31:0], ST_TOO_MANY);
                                    walk_state = WALK_DONE;
                                end else begin
                                    walk_state = WALK_BODY;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
                if (walk_state != WALK_DONE) begin
                    pos = pos + 1'b1;
                    // Reaching the next entry: its tag must at least fit in the file.
                    if (walk_state == WALK_BODY && {1'b0, pos} == base) begin
                        walk_state = WALK_TAG;
                        tag_acc = '0;
                        if ({1'b0, base} + 34'd4 > len34) begin
                            queue_record(RK_STATUS, '0, '0, base[31:0], ST_RAN_OFF);
                            walk_state = WALK_DONE;
                        end
                    end
                end
            end
            if (pending_records.size() > first)
                pending_records[pending_records.size() - 1].last = 1'b1;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("[%0t] record %0d: %s", $realtime, records, msg);
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got %h, expected %h", name, got, want));
        endtask

        task check_record(logic kind, logic [119:0] d, logic lst);
            result_t want;
            if (pending_records.size() == 0) begin
                report($sformatf("unexpected record, kind %b tdata %h", kind, d));
            end else begin
                want = pending_records.pop_front();
                compare_field("result kind", 32'(kind), 32'(want.result_kind));
                compare_field("entry tag", d[31:0], want.entry_tag);
                compare_field("entry size", d[63:32], want.entry_size);
                compare_field("entry offset", d[95:64], want.entry_offset);
                compare_field("status", 32'(d[98:96]), 32'(want.status));
                compare_field("occluder", 32'(d[99]), 32'(want.occluder));
                compare_field("entry count", 32'(d[117:100]), 32'(want.entry_count));
                compare_field("padding", 32'(d[119:118]), 32'd0);
                compare_field("tlast", 32'(lst), 32'(want.last));
                if (want.result_kind == RK_STATUS)
                    status_hits[want.status]++;
                records++;
            end
        endtask
    endclass

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [119:0] m_tdata;
    logic         m_tuser;
    logic         m_tlast;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    walk_scoreboard sb;
    int     accepted;
    int     files;
    int     rx_hold;
    int     rx_free;
    bit     long_hold_done;
    bit     hold_request;
    longint cycles;

    chunk_chain_walker dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    // Result side: checks each transaction and throttles m_tready, with one long hold-off
    // during the pressure file so that the output queue fills and the input stalls.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                sb.check_record(m_tuser, m_tdata, m_tlast);
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else if (!long_hold_done && hold_request) begin
                long_hold_done = 1'b1;
                rx_hold = 400;
                m_tready <= 1'b0;
            end else if (rx_free > 0) begin
                rx_free--;
                m_tready <= 1'b1;
            end else begin
                case ($urandom_range(0, 19))
                    0: begin
                        rx_free = 150;
                        m_tready <= 1'b1;
                    end
                    1, 2, 3, 4: begin
                        rx_hold = pick_gap() - 1;
                        m_tready <= 1'b0;
                    end
                    default: m_tready <= 1'b1;
                endcase
            end
        end
    end

    task automatic send_item(input logic kind, input logic [7:0] b, input bit gaps);
        bit ready_seen;
        if (gaps && $urandom_range(0, 99) < 20) begin
            s_tvalid <= 1'b0;
            repeat (pick_gap()) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= b;
        do begin
            @(negedge aclk);
            ready_seen = s_tready;
            @(posedge aclk);
        end while (!ready_seen);
        sb.note_input(kind, b);
        accepted++;
    endtask

    task automatic send_le32(input logic [31:0] w, input bit gaps);
        for (int i = 0; i < 4; i++)
            send_item(KIND_DATA, w[8*i +: 8], gaps);
    endtask

    // Drops the input and waits until every predicted record has been seen.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending_records.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_length(input logic [31:0] v);
        logic [31:0] rb;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_FILE_LENGTH, 2'b00};
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        sb.flen = v;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        rb = prdata;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (rb !== v)
            sb.report($sformatf("file_length read back %h, written %h", rb, v));
    endtask

    function automatic void put_le32(ref logic [7:0] q[$], input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            q.push_back(w[8*i +: 8]);
    endfunction

    // One file: mostly a well-formed chain with random tags and bodies, then a declared
    // length and optional damage chosen to reach every walk ending but the entry limit.
    task automatic stream_random_file();
        logic [7:0]  img[$];
        logic [31:0] len;
        logic [31:0] tag;
        int          sz;
        int          term_at;
        int          stop_at;
        int          relen_at;
        int          pick;
        bit          gaps;
        put_le32(img, $urandom_range(0, 1) ? MAGIC_OCCL : MAGIC_PLAIN);
        put_le32(img, $urandom);
        put_le32(img, HDR_WORD_SIZE);
        put_le32(img, HDR_WORD_ONE);
        repeat ($urandom_range(0, 5)) begin
            sz = ($urandom_range(0, 3) == 0) ? 8 : $urandom_range(8, 20);
            tag = $urandom;
            if (tag == 0)
                tag = 32'd1;
            put_le32(img, tag);
            put_le32(img, ($urandom_range(0, 14) == 0) ? $urandom_range(0, 7) : sz);
            repeat (sz - 8) img.push_back(8'($urandom));
        end
        term_at = img.size();
        put_le32(img, 32'd0);
        put_le32(img, $urandom);

        if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 2))
                0: pick = $urandom_range(0, 3);
                1: pick = $urandom_range(8, 15);
                default: pick = $urandom_range(0, img.size() - 1);
            endcase
            img[pick] = 8'($urandom);
        end

        stop_at = img.size();
        pick = $urandom_range(0, 99);
        if (pick < 45)
            len = term_at + $urandom_range(0, 8);
        else if (pick < 70)
            len = $urandom_range(HEADER_BYTES, img.size());
        else if (pick < 78) begin
            len = $urandom_range(0, HEADER_BYTES - 1);
            stop_at = 6;
        end else if (pick < 86)
            len = 32'hFFFF_FFFF;
        else
            len = $urandom;
        if ($urandom_range(0, 6) == 0)
            stop_at = $urandom_range(1, stop_at - 1);
        relen_at = ($urandom_range(0, 19) == 0) ? $urandom_range(4, stop_at - 1) : -1;
        gaps = ($urandom_range(0, 3) != 0);

        settle();
        write_length(len);
        files++;
        send_item(KIND_START, 8'($urandom), gaps);
        for (int i = 0; i < stop_at; i++) begin
            if (i == relen_at) begin
                // The block is idle between bytes, so the length may change mid-walk.
                settle();
                write_length($urandom_range(HEADER_BYTES, img.size() + 4));
            end
            send_item(KIND_DATA, img[i], gaps);
        end
    endtask

    // A chain of eight-byte entries streamed without gaps while the receiver holds off,
    // so that the result queue fills up and the input stalls.
    task automatic stream_pressure_file();
        logic [31:0] tag;
        settle();
        write_length(32'(HEADER_BYTES + 8 * PRESSURE_ENTRIES + 8));
        files++;
        hold_request = 1'b1;
        send_item(KIND_START, 8'h00, 1'b0);
        send_le32(MAGIC_PLAIN, 1'b0);
        send_le32(32'h0, 1'b0);
        send_le32(HDR_WORD_SIZE, 1'b0);
        send_le32(HDR_WORD_ONE, 1'b0);
        repeat (PRESSURE_ENTRIES) begin
            tag = $urandom | 32'h1;
            send_le32(tag, 1'b0);
            send_le32(MIN_ENTRY, 1'b0);
        end
        send_le32(32'h0, 1'b0);
        send_le32($urandom, 1'b0);
    endtask

    initial begin
        int random_base;
        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Bytes straight out of reset with no start transaction: the length is still
        // zero, so the magic check fails on the fourth byte.
        send_le32(MAGIC_PLAIN, 1'b0);
        settle();
        // A length below the header size is refused by the start transaction itself.
        write_length(32'd8);
        send_item(KIND_START, 8'h00, 1'b0);
        settle();
        // Smallest complete file: occluder header then a zero tag; the extra byte is ignored.
        write_length(32'd20);
        send_item(KIND_START, 8'hFF, 1'b0);
        send_le32(MAGIC_OCCL, 1'b0);
        send_le32(32'hFFFF_FFFF, 1'b0);
        send_le32(HDR_WORD_SIZE, 1'b0);
        send_le32(HDR_WORD_ONE, 1'b0);
        send_le32(32'h0, 1'b0);
        send_item(KIND_DATA, 8'hA5, 1'b0);
        settle();
        stream_pressure_file();
        settle();

        random_base = accepted;
        while (accepted - random_base < RANDOM_ITEMS)
            stream_random_file();
        settle();

        $display("Streamed %0d files in %0d input transactions, %0d records checked.",
                 files, accepted, sb.records);
        $display("Final statuses: complete %0d, not magic %0d, header bad %0d, ran off %0d, %s",
                 sb.status_hits[ST_COMPLETE], sb.status_hits[ST_NOT_MAGIC],
                 sb.status_hits[ST_HEADER_BAD], sb.status_hits[ST_RAN_OFF],
                 $sformatf("no size %0d, bad size %0d, too many %0d",
                           sb.status_hits[ST_NO_SIZE], sb.status_hits[ST_BAD_SIZE],
                           sb.status_hits[ST_TOO_MANY]));
        if (sb.errors == 0 && sb.pending_records.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> chunk_chain_walker.f
hw/rtl/ccw_pkg.sv
hw/rtl/ccw_parse.sv
hw/rtl/ccw_outq.sv
hw/rtl/chunk_chain_walker.sv
dv/chunk_chain_walker_tb.sv
